FILE: rtl/mbe_pkg.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Widths, fixed-point constants, palette and saturation shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package mbe_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 28;
    localparam int COUNT_WIDTH = 16;
    localparam int PIXEL_WIDTH = 32;
    localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
    localparam int WIDE_WIDTH  = 2 * COORD_WIDTH + 2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [WIDE_WIDTH-1:0]  wide_t;
    typedef logic [COUNT_WIDTH-1:0]        count_t;
    typedef logic [PIXEL_WIDTH-1:0]        pixel_t;

    localparam count_t MAX_ITER_RESET = count_t'(256);

    // Escape threshold 4.0 at the scale of a full-width square.
    localparam wide_t FOUR_VAL = wide_t'(1) <<< (2 * FRAC_BITS + 2);

    localparam pixel_t PIXEL_BLACK = 32'hFF00_0000;

    // Palette entry as {blue, green, red}, each channel full on or off.
    function automatic logic [2:0] palette_rgb(input logic [2:0] idx);
        logic [2:0] rgb;
        case (idx)
            3'd0:    rgb = 3'b100;
            3'd1:    rgb = 3'b110;
            3'd2:    rgb = 3'b111;
            3'd3:    rgb = 3'b011;
            3'd4:    rgb = 3'b001;
            3'd5:    rgb = 3'b000;
            3'd6:    rgb = 3'b010;
            default: rgb = 3'b000;
        endcase
        return rgb;
    endfunction

    // Clamp a wide signed value to the coordinate range.
    function automatic coord_t sat_coord(input wide_t v);
        logic [WIDE_WIDTH-COORD_WIDTH:0] top;
        coord_t                          res;
        top = v[WIDE_WIDTH-1:COORD_WIDTH-1];
        if (top == '0 || top == '1) begin
            res = v[COORD_WIDTH-1:0];
        end else if (v[WIDE_WIDTH-1]) begin
            res = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mbe_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed coordinate by coordinate product, registered at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_mul (
    input  wire              clk,
    input  mbe_pkg::coord_t  op_a,
    input  mbe_pkg::coord_t  op_b,
    output mbe_pkg::prod_t   prod
);

    mbe_pkg::prod_t prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= mbe_pkg::PROD_WIDTH'(op_a) * mbe_pkg::PROD_WIDTH'(op_b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

FILE: rtl/mbe_color.sv
// ----------------------------------------------------------------------------
// Escape count color mapper
// Blends two neighboring palette entries by the low count bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_color (
    input  mbe_pkg::count_t  count,
    input  mbe_pkg::count_t  limit,
    output mbe_pkg::pixel_t  pixel
);

    logic [7:0] grade;
    logic [2:0] idx0;
    logic [2:0] idx1;
    logic [2:0] rgb0;
    logic [2:0] rgb1;
    logic [7:0] chan [3];

    assign grade = {count[5:0], 2'b00};
    assign idx0  = count[8:6];
    assign idx1  = idx0 + 3'd1;
    assign rgb0  = mbe_pkg::palette_rgb(idx0);
    assign rgb1  = mbe_pkg::palette_rgb(idx1);

    // Each channel weight is zero or one, so the blend reduces to a select.
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++) begin
            case ({rgb0[ch], rgb1[ch]})
                2'b11:   chan[ch] = 8'hFF;
                2'b10:   chan[ch] = 8'hFF - grade;
                2'b01:   chan[ch] = grade;
                default: chan[ch] = 8'h00;
            endcase
        end
    end

    assign pixel = (count == limit) ? mbe_pkg::PIXEL_BLACK
                                    : {8'hFF, chan[2], chan[1], chan[0]};

endmodule

`default_nettype wire

FILE: rtl/mandelbrot_escape_time_color_unit.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time color unit
// Iterates z = z*z + c on one point with a shared multiplier and maps the
// escape count to an RGBA word.
// Each iteration runs one shared multiplier pass each for the real square,
// the imaginary square and the cross product, then the escape test and the
// update; an escaping point leaves at the test, and a finishing state then
// registers the result word together with done.
// Throughput: one point at a time; busy stays high until the result word.
// The result is shown for one cycle on done; the receiver cannot stall.
// Reset clears the sequencer and sets the iteration limit to 256.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time_color_unit (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              start,
    output logic             busy,
    input  mbe_pkg::coord_t  c_real,
    input  mbe_pkg::coord_t  c_imag,
    input  wire              cfg_we,
    input  mbe_pkg::count_t  cfg_wdata,
    output logic             done,
    output mbe_pkg::pixel_t  pixel_rgba,
    output mbe_pkg::count_t  escape_count
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MRR  = 3'd1;
    localparam logic [2:0] ST_MII  = 3'd2;
    localparam logic [2:0] ST_MRI  = 3'd3;
    localparam logic [2:0] ST_TEST = 3'd4;
    localparam logic [2:0] ST_UPD  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    mbe_pkg::count_t  max_iter_reg;
    mbe_pkg::count_t  count_reg;
    mbe_pkg::count_t  count_inc;
    mbe_pkg::coord_t  cr_reg;
    mbe_pkg::coord_t  ci_reg;
    mbe_pkg::coord_t  zr_reg;
    mbe_pkg::coord_t  zi_reg;
    mbe_pkg::prod_t   rr_reg;
    mbe_pkg::prod_t   ii_reg;
    mbe_pkg::prod_t   ri_reg;
    mbe_pkg::wide_t   diff_reg;
    mbe_pkg::wide_t   mag_sum;
    mbe_pkg::wide_t   new_re;
    mbe_pkg::wide_t   new_im;
    mbe_pkg::coord_t  mul_a;
    mbe_pkg::coord_t  mul_b;
    mbe_pkg::prod_t   prod;
    mbe_pkg::pixel_t  pixel_val;
    logic             escaped;
    logic             done_reg;
    mbe_pkg::pixel_t  pixel_reg;
    mbe_pkg::count_t  esc_count_reg;

    always_comb
    begin
        unique case (state_reg)
            ST_MRR:  begin mul_a = zr_reg; mul_b = zr_reg; end
            ST_MII:  begin mul_a = zi_reg; mul_b = zi_reg; end
            default: begin mul_a = zr_reg; mul_b = zi_reg; end
        endcase
    end

    mbe_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    mbe_color u_color (
        .count (count_reg),
        .limit (max_iter_reg),
        .pixel (pixel_val)
    );

    assign count_inc = count_reg + mbe_pkg::count_t'(1);
    assign mag_sum   = mbe_pkg::WIDE_WIDTH'(rr_reg) + mbe_pkg::WIDE_WIDTH'(ii_reg);
    assign escaped   = (mag_sum >= mbe_pkg::FOUR_VAL);

    // Rescale with floor rounding; the cross product is doubled by shifting one less.
    assign new_re = (diff_reg >>> mbe_pkg::FRAC_BITS) + mbe_pkg::WIDE_WIDTH'(cr_reg);
    assign new_im = (mbe_pkg::WIDE_WIDTH'(ri_reg) >>> (mbe_pkg::FRAC_BITS - 1))
                  + mbe_pkg::WIDE_WIDTH'(ci_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start) begin
                    state_next = (max_iter_reg == '0) ? ST_DONE : ST_MRR;
                end
            end
            ST_MRR:  state_next = ST_MII;
            ST_MII:  state_next = ST_MRI;
            ST_MRI:  state_next = ST_TEST;
            ST_TEST: state_next = escaped ? ST_DONE : ST_UPD;
            ST_UPD:  state_next = (count_inc < max_iter_reg) ? ST_MRR : ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= ST_IDLE;
            max_iter_reg <= mbe_pkg::MAX_ITER_RESET;
            count_reg    <= '0;
            done_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_DONE);
            if (cfg_we) begin
                max_iter_reg <= cfg_wdata;
            end
            if (state_reg == ST_IDLE && start) begin
                count_reg <= '0;
            end else if (state_reg == ST_UPD) begin
                count_reg <= count_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start) begin
            cr_reg <= c_real;
            ci_reg <= c_imag;
            zr_reg <= '0;
            zi_reg <= '0;
        end
        if (state_reg == ST_MII) begin
            rr_reg <= prod;
        end
        if (state_reg == ST_MRI) begin
            ii_reg <= prod;
        end
        if (state_reg == ST_TEST) begin
            ri_reg   <= prod;
            diff_reg <= mbe_pkg::WIDE_WIDTH'(rr_reg) - mbe_pkg::WIDE_WIDTH'(ii_reg);
        end
        if (state_reg == ST_UPD) begin
            zr_reg <= mbe_pkg::sat_coord(new_re);
            zi_reg <= mbe_pkg::sat_coord(new_im);
        end
        if (state_reg == ST_DONE) begin
            pixel_reg     <= pixel_val;
            esc_count_reg <= count_reg;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign pixel_rgba   = pixel_reg;
    assign escape_count = esc_count_reg;

endmodule

`default_nettype wire

FILE: tb/mandelbrot_escape_time_color_unit_test.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// Mandelbrot escape-time color unit testbench
// Feeds points through a directed set and then random phases at several
// iteration limits, including the register's extremes. Each point's escape
// count and color are worked out in the bench and checked against the
// result word in order of arrival.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_color_unit_test;

    localparam int HALF_PERIOD   = 6;
    localparam int FRAC          = mbe_pkg::FRAC_BITS;
    localparam int CW            = mbe_pkg::COORD_WIDTH;
    localparam int ONE           = 1 << FRAC;
    localparam int RESET_LIMIT   = 256;
    localparam int COUNT_CAP     = 700;
    localparam int MAX_GAP       = 60;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 40;
    localparam int PHASE_ITEMS   = 135;
    localparam int ZERO_ITEMS    = 4;

    typedef logic signed [2*CW+3:0] acc_t;

    localparam acc_t ESCAPE_RADIUS_SQ = acc_t'(1) <<< (2 * FRAC + 2);
    localparam acc_t COORD_HI         = (acc_t'(1) <<< (CW - 1)) - acc_t'(1);
    localparam acc_t COORD_LO         = -(acc_t'(1) <<< (CW - 1));

    localparam mbe_pkg::pixel_t OPAQUE_BLACK = 32'hFF00_0000;

    // Eight palette entries, three bits each as {blue, green, red}, entry 0 lowest.
    localparam logic [23:0] PALETTE_BGR = {3'b000, 3'b010, 3'b000, 3'b001,
                                           3'b011, 3'b111, 3'b110, 3'b100};

    typedef enum bit {JOB_POINT, JOB_LIMIT} job_kind_t;

    typedef struct {
        job_kind_t        kind;
        mbe_pkg::count_t  limit;
        mbe_pkg::coord_t  cr;
        mbe_pkg::coord_t  ci;
    } job_t;

    typedef struct {
        mbe_pkg::pixel_t  pixel;
        mbe_pkg::count_t  count;
    } shade_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    mbe_pkg::coord_t  c_real = '0;
    mbe_pkg::coord_t  c_imag = '0;
    logic             cfg_we = 1'b0;
    mbe_pkg::count_t  cfg_wdata = '0;
    logic             done;
    mbe_pkg::pixel_t  pixel_rgba;
    mbe_pkg::count_t  escape_count;

    job_t             work_q[$];
    shade_t           expected_shades[$];
    int unsigned      limit_now = RESET_LIMIT;
    int unsigned      gen_limit = RESET_LIMIT;
    int unsigned      burst_left = 1;
    int unsigned      gap_left = 0;
    int unsigned      quiet_cycles = 0;
    int unsigned      mismatches = 0;
    longint unsigned  cycle_count = 0;
    longint unsigned  cycle_budget = 0;
    longint unsigned  cycle_limit = 64'hFFFF_FFFF;

    mandelbrot_escape_time_color_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .c_real       (c_real),
        .c_imag       (c_imag),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .pixel_rgba   (pixel_rgba),
        .escape_count (escape_count)
    );

    initial
    begin
        forever #HALF_PERIOD clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic mbe_pkg::coord_t clamp_coord(input acc_t v);
        mbe_pkg::coord_t r;
        if (v > COORD_HI) begin
            r = COORD_HI[CW-1:0];
        end else if (v < COORD_LO) begin
            r = COORD_LO[CW-1:0];
        end else begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    // Squares and cross product are exact; rescaling floors toward minus infinity.
    function automatic int unsigned escape_iters(input mbe_pkg::coord_t cr,
                                                 input mbe_pkg::coord_t ci,
                                                 input int unsigned limit);
        mbe_pkg::coord_t zr;
        mbe_pkg::coord_t zi;
        acc_t            rr;
        acc_t            ii;
        acc_t            ri;
        int unsigned     n;
        bit              escaped;
        zr      = '0;
        zi      = '0;
        n       = 0;
        escaped = 1'b0;
        while (n < limit && !escaped) begin
            rr = acc_t'(zr) * acc_t'(zr);
            ii = acc_t'(zi) * acc_t'(zi);
            if (rr + ii >= ESCAPE_RADIUS_SQ) begin
                escaped = 1'b1;
            end else begin
                ri = acc_t'(zr) * acc_t'(zi);
                zr = clamp_coord(((rr - ii) >>> FRAC) + acc_t'(cr));
                zi = clamp_coord((ri >>> (FRAC - 1)) + acc_t'(ci));
                n++;
            end
        end
        return n;
    endfunction

    function automatic mbe_pkg::pixel_t shade_of(input int unsigned n,
                                                 input int unsigned limit);
        mbe_pkg::pixel_t word;
        int unsigned     grade;
        int unsigned     e0;
        int unsigned     e1;
        int unsigned     v;
        word = OPAQUE_BLACK;
        if (n != limit) begin
            grade = (n * 4) % 256;
            e0    = (n / 64) % 8;
            e1    = (e0 + 1) % 8;
            for (int ch = 0; ch < 3; ch++) begin
                v = (255 - grade) * PALETTE_BGR[3*e0+ch] + grade * PALETTE_BGR[3*e1+ch];
                word[8*ch +: 8] = v[7:0];
            end
        end
        return word;
    endfunction

    task automatic queue_point(input mbe_pkg::coord_t cr, input mbe_pkg::coord_t ci);
        job_t job;
        job.kind  = JOB_POINT;
        job.limit = '0;
        job.cr    = cr;
        job.ci    = ci;
        work_q.push_back(job);
        cycle_budget += 5 * ((gen_limit < COUNT_CAP) ? gen_limit : COUNT_CAP) + 8 + MAX_GAP;
    endtask

    task automatic queue_limit(input int unsigned value);
        job_t job;
        job.kind  = JOB_LIMIT;
        job.limit = mbe_pkg::count_t'(value);
        job.cr    = '0;
        job.ci    = '0;
        work_q.push_back(job);
        gen_limit = value;
        cycle_budget += SETTLE_CYCLES + 8;
    endtask

    // Sender: points go out in bursts with random gaps. A limit write waits
    // until the unit has been idle with nothing outstanding long enough to pass the settle check.
    always @(posedge clk)
    begin : feed_points
        logic        nxt_start;
        logic        nxt_we;
        int unsigned n;
        int unsigned pick;
        job_t        job;
        shade_t      want;
        if (rst_n) begin
            nxt_start = start;
            nxt_we    = 1'b0;
            if (start && !busy) begin
                n          = escape_iters(c_real, c_imag, limit_now);
                want.pixel = shade_of(n, limit_now);
                want.count = mbe_pkg::count_t'(n);
                expected_shades.push_back(want);
                nxt_start = 1'b0;
            end
            if (!busy && !done && !start && expected_shades.size() == 0) begin
                quiet_cycles++;
            end else begin
                quiet_cycles = 0;
            end
            if (!nxt_start && work_q.size() > 0) begin
                if (work_q[0].kind == JOB_LIMIT) begin
                    if (quiet_cycles >= SETTLE_CYCLES) begin
                        job          = work_q.pop_front();
                        cfg_wdata   <= job.limit;
                        nxt_we       = 1'b1;
                        limit_now    = job.limit;
                        quiet_cycles = 0;
                    end
                end else if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    job       = work_q.pop_front();
                    c_real   <= job.cr;
                    c_imag   <= job.ci;
                    nxt_start = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        pick       = $urandom_range(0, 99);
                        if (pick < 30) begin
                            gap_left = 0;
                        end else if (pick < 75) begin
                            gap_left = $urandom_range(1, 8);
                        end else if (pick < 92) begin
                            gap_left = $urandom_range(9, 30);
                        end else begin
                            gap_left = $urandom_range(31, MAX_GAP);
                        end
                    end
                end
            end
            start  <= nxt_start;
            cfg_we <= nxt_we;
        end
    end

    always @(posedge clk)
    begin : check_results
        shade_t want;
        if (rst_n && done) begin
            if (expected_shades.size() == 0) begin
                $display("%0t: result word with no point pending: pixel %h count %0d",
                         $time, pixel_rgba, escape_count);
                mismatches++;
            end else begin
                want = expected_shades.pop_front();
                if (pixel_rgba !== want.pixel) begin
                    $display("%0t: pixel_rgba expected %h actual %h",
                             $time, want.pixel, pixel_rgba);
                    mismatches++;
                end
                if (escape_count !== want.count) begin
                    $display("%0t: escape_count expected %0d actual %0d",
                             $time, want.count, escape_count);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : run
        int unsigned     phase_limits [13];
        int unsigned     items;
        int unsigned     pick;
        int              cr;
        int              ci;

        // Directed points at the reset limit.
        queue_point('0, '0);
        queue_point(32'h8000_0000, 32'h8000_0000);
        queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_point(32'h8000_0000, 32'h7FFF_FFFF);
        queue_point(32'h7FFF_FFFF, 32'h8000_0000);
        queue_point(-2 * ONE, 0);
        queue_point(2 * ONE, 0);
        queue_point(0, -2 * ONE);
        queue_point(0, 2 * ONE - 1);
        queue_point(-2 * ONE + 1, 0);
        queue_point(ONE / 4, 0);
        queue_point(ONE / 4 + ONE / 64, 0);
        queue_point(-ONE, 0);
        queue_point(0, ONE);
        queue_point(-3 * ONE / 4, ONE / 20);
        queue_point(1, -1);
        queue_point(-1, 1);

        // A limit of zero gets only a handful of points.
        phase_limits = '{1, 65535, 2, 520, 6, 33, 0, 1000, 3, 129, 256, 65534, 0};
        phase_limits[12] = $urandom_range(8, 300);
        for (int p = 0; p < 13; p++) begin
            queue_limit(phase_limits[p]);
            items = (phase_limits[p] == 0) ? ZERO_ITEMS : PHASE_ITEMS;
            for (int k = 0; k < items; k++) begin
                // Above the cap, points that do not escape within the cap are redrawn.
                do begin
                    pick = $urandom_range(0, 99);
                    if (pick < 55) begin
                        cr = int'($urandom_range(0, 3 * ONE)) - 9 * (ONE / 4);
                        ci = int'($urandom_range(0, 3 * ONE)) - 3 * ONE / 2;
                    end else if (pick < 75) begin
                        case ($urandom_range(0, 3))
                            0: begin
                                cr = -3 * ONE / 4 + int'($urandom_range(0, 1 << 17)) - (1 << 16);
                                ci = int'($urandom_range(1 << 18, 1 << 22));
                            end
                            1: begin
                                cr = ONE / 4 + int'($urandom_range(0, 1 << 22));
                                ci = int'($urandom_range(0, 1 << 16));
                            end
                            2: begin
                                cr = -5 * ONE / 4 - int'($urandom_range(0, 1 << 22));
                                ci = int'($urandom_range(0, 1 << 20));
                            end
                            default: begin
                                cr = -2 * ONE + int'($urandom_range(0, 1 << 20));
                                ci = int'($urandom_range(0, 1 << 12));
                            end
                        endcase
                        if ($urandom_range(0, 1) == 1) begin
                            ci = -ci;
                        end
                    end else if (pick < 90) begin
                        cr = $urandom;
                        ci = $urandom;
                    end else begin
                        cr = int'($urandom_range(0, 511)) - 256;
                        ci = int'($urandom_range(0, 511)) - 256;
                    end
                end while (gen_limit > COUNT_CAP &&
                           escape_iters(cr, ci, COUNT_CAP) == COUNT_CAP);
                queue_point(cr, ci);
            end
        end
        cycle_limit = 4 * cycle_budget + 10_000;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Sample on the falling edge so that the sender's updates have settled.
        while ((work_q.size() > 0 || start || expected_shades.size() > 0) &&
               cycle_count < cycle_limit) begin
            @(negedge clk);
        end

        if (cycle_count >= cycle_limit) begin
            $display("%0t: timeout, %0d points unsent, %0d results outstanding",
                     $time, work_q.size(), expected_shades.size());
            $display("mandelbrot_escape_time_color_unit_test: done, errors");
        end else begin
            repeat (DRAIN_CYCLES) @(posedge clk);
            if (mismatches == 0) begin
                $display("mandelbrot_escape_time_color_unit_test: done, clean");
            end else begin
                $display("mandelbrot_escape_time_color_unit_test: done, errors");
            end
        end
        $finish;
    end

endmodule
